@@ rtl/core/adjacency_list_transpose_defines.svh @@
// Assertion macros shared by the adjacency list transpose RTL.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef ADJACENCY_LIST_TRANSPOSE_DEFINES_SVH
`define ADJACENCY_LIST_TRANSPOSE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ALT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alt: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ALT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alt: next-cycle check failed");
`else
`define ALT_ASSERT_IMP(name, ante, cons)
`define ALT_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ rtl/core/alt_pkg.sv @@
// Shared types and constants for the adjacency list transpose block.
// No dependencies; compiled before the interfaces and modules.
package alt_pkg;

  // Fixed field widths of the channels and the config register
  localparam int NT_W   = 11;
  localparam int SRC_W  = 16;
  localparam int TGT_W  = 10;
  localparam int VAL_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [NT_W-1:0] NT_RESET = 11'd1024;

  // Default store sizes
  localparam int MAX_TARGETS_DEF = 1024;
  localparam int MAX_LINKS_DEF   = 4096;

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Word kind codes
  localparam logic KIND_OFFSET = 1'b0;
  localparam logic KIND_LINK   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_BUSY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_LOAD,
    S_PREFIX,
    S_SCATTER,
    S_READ
  } fsm_state_t;

  // Phase flags from the sequencer
  typedef struct packed {
    logic load_on;
    logic read_on;
    logic prefix_on;
    logic scatter_on;
    logic sweep_on;
  } ctl_t;

  // Events from the datapath that move the sequencer
  typedef struct packed {
    logic build_start;
    logic scatter_done;
    logic read_end;
  } ctl_ev_t;

endpackage

@@ rtl/core/alt_in_if.sv @@
// Input channel of the adjacency list transpose: valid/ready plus one item.
// Depends on alt_pkg for field widths.
interface alt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [alt_pkg::SRC_W-1:0]  source_node;
  logic [alt_pkg::TGT_W-1:0]  target_entity;

  modport source (output valid, action, source_node, target_entity, input ready);
  modport sink   (input valid, action, source_node, target_entity, output ready);
endinterface

@@ rtl/core/alt_out_if.sv @@
// Result channel of the adjacency list transpose: valid/ready plus one word.
// Depends on alt_pkg for field widths.
interface alt_out_if;
  logic                        valid;
  logic                        ready;
  logic [alt_pkg::STAT_W-1:0]  status;
  logic                        word_kind;
  logic [alt_pkg::VAL_W-1:0]   word_value;
  logic                        last_word;

  modport source (output valid, status, word_kind, word_value, last_word, input ready);
  modport sink   (input valid, status, word_kind, word_value, last_word, output ready);
endinterface

@@ rtl/core/adjacency_list_transpose.sv @@
// Adjacency list transpose (CSR sparse transpose), top level; uses alt_pkg, alt_in_if,
// alt_out_if, alt_ctrl and the assertion macros. Load items (action 0) store one link and
// bump a per-target count in the count memory; loads stream at one per clock while the
// output is not stalled, with a forward path for back-to-back loads to the same target.
// The first read of a job stalls input while the sequencer sweeps all MAX_TARGETS count
// entries (forming prefix offsets and clearing the counts) and then scatters the stored
// links into target rows through the row pointer memory, one link per cycle. Every further
// read returns one word, offsets first, then connections. Results leave through the result
// stage register and then the output register. After reset, a clearing pass over all
// MAX_TARGETS (1024 by default) count entries runs before the first item is taken.
`include "adjacency_list_transpose_defines.svh"

module adjacency_list_transpose #(
  parameter int MAX_TARGETS = alt_pkg::MAX_TARGETS_DEF,
  parameter int MAX_LINKS   = alt_pkg::MAX_LINKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [alt_pkg::NT_W-1:0]  cfg_wdata,
  alt_in_if.sink                    in_ch,
  alt_out_if.source                 out_ch
);

  localparam int TI = $clog2(MAX_TARGETS);
  localparam int LI = $clog2(MAX_LINKS);
  localparam int LC = $clog2(MAX_LINKS + 1);
  localparam int RW = $clog2(MAX_TARGETS + 1);
  localparam int PW = $clog2(MAX_TARGETS + MAX_LINKS + 2);
  localparam int CW = (RW > alt_pkg::NT_W) ? RW : alt_pkg::NT_W;
  localparam int LW = alt_pkg::TGT_W + alt_pkg::SRC_W;

  typedef enum logic [1:0] {
    VSEL_NONE,
    VSEL_ROW,
    VSEL_LINK
  } vsel_t;

  // Sequencer
  alt_pkg::ctl_t    ctl;
  alt_pkg::ctl_ev_t ev;
  logic [TI-1:0]    sweep;

  alt_ctrl #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .ctl       (ctl),
    .sweep_idx (sweep)
  );

  // Registers
  logic [alt_pkg::NT_W-1:0] nt_r;
  logic [RW-1:0]            job_rows_r;
  logic [LC-1:0]            links_loaded_r;
  logic [PW-1:0]            pos_r;
  logic                     pend_r;

  logic                     pv_r;
  logic [TI-1:0]            paddr_r;
  logic [LC-1:0]            run_r;

  logic [LC-1:0]            si_r;
  logic                     sb_v_r;
  logic                     sc_v_r;
  logic [TI-1:0]            sc_tg_r;
  logic [alt_pkg::SRC_W-1:0] sc_src_r;

  logic                     s1_v_r;
  alt_pkg::status_t         s1_stat_r;
  vsel_t                    s1_sel_r;
  logic                     s1_kind_r;
  logic                     s1_last_r;
  logic                     s1_inc_r;
  logic [TI-1:0]            s1_addr_r;

  logic                     lwc_v_r;
  logic [TI-1:0]            lwc_addr_r;
  logic [LC-1:0]            lwc_data_r;
  logic                     lwf_v_r;
  logic [TI-1:0]            lwf_addr_r;
  logic [LC-1:0]            lwf_data_r;

  logic                     out_v_r;
  alt_pkg::status_t         out_stat_r;
  logic                     out_kind_r;
  logic [alt_pkg::VAL_W-1:0] out_val_r;
  logic                     out_last_r;

  // Memories and their read registers
  logic [LW-1:0]             link_mem [MAX_LINKS];
  logic [LW-1:0]             link_rd_r;
  logic [LC-1:0]             cnt_mem  [MAX_TARGETS];
  logic [LC-1:0]             cnt_rd_r;
  logic [LC-1:0]             fill_mem [MAX_TARGETS];
  logic [LC-1:0]             fill_rd_r;
  logic [alt_pkg::SRC_W-1:0] tr_mem   [MAX_LINKS];
  logic [alt_pkg::SRC_W-1:0] tr_rd_r;

  // Front stage signals
  logic [RW-1:0]    eff_rows;
  logic             adv;
  logic             in_ready;
  logic             in_acc;
  logic             is_read;
  logic             inject;
  logic             build_start;
  logic             rd_issue;
  logic             ld_issue;
  alt_pkg::status_t ld_stat;
  logic             ld_ok;
  logic [PW-1:0]    total;
  logic [PW-1:0]    pos_p1;
  logic             rd_row;
  logic             rd_last;
  logic [PW-1:0]    rd_k;
  vsel_t            rd_sel;

  // Memory port signals
  logic             c_re, c_we;
  logic [TI-1:0]    c_raddr, c_waddr;
  logic [LC-1:0]    c_wdata, c_cur, cnt_inc;
  logic             f_re, f_we;
  logic [TI-1:0]    f_raddr, f_waddr;
  logic [LC-1:0]    f_wdata;
  logic             sa_go;
  logic [alt_pkg::TGT_W-1:0] link_tg;
  logic             sb_hit;
  logic             p_hit;
  logic [LC-1:0]    slot, slot_p1;
  logic [alt_pkg::VAL_W-1:0] s1_val;

  // Clamp the row count to the store size
  assign eff_rows = (CW'(nt_r) > CW'(MAX_TARGETS)) ? RW'(MAX_TARGETS) : RW'(nt_r);

  // Handshake and item routing
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ready    = adv && (ctl.load_on || (ctl.read_on && !pend_r));
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign is_read     = (in_ch.action == alt_pkg::ACT_READ);
  assign inject      = ctl.read_on && pend_r && adv;
  assign build_start = in_acc && ctl.load_on && is_read;
  assign rd_issue    = inject || (in_acc && ctl.read_on && is_read);
  assign ld_issue    = in_acc && !is_read;

  assign ev.build_start  = build_start;
  assign ev.scatter_done = ctl.scatter_on && (si_r == links_loaded_r)
                           && !sb_v_r && !sc_v_r && !pv_r;
  assign ev.read_end     = rd_issue && rd_last;

  // Load status: readout busy first, then range, then full store
  always_comb begin
    priority if (ctl.read_on) begin
      ld_stat = alt_pkg::STAT_BUSY;
    end else if (CW'(in_ch.target_entity) >= CW'(eff_rows)) begin
      ld_stat = alt_pkg::STAT_RANGE;
    end else if (links_loaded_r >= LC'(MAX_LINKS)) begin
      ld_stat = alt_pkg::STAT_FULL;
    end else begin
      ld_stat = alt_pkg::STAT_OK;
    end
  end
  assign ld_ok = ld_issue && (ld_stat == alt_pkg::STAT_OK);

  // Readout position decode
  assign total   = PW'(job_rows_r) + PW'(run_r) + PW'(1);
  assign pos_p1  = pos_r + PW'(1);
  assign rd_row  = (pos_r <= PW'(job_rows_r));
  assign rd_last = (pos_p1 >= total);
  assign rd_k    = pos_r - PW'(job_rows_r) - PW'(1);

  always_comb begin
    if (!rd_row) begin
      rd_sel = VSEL_LINK;
    end else if (pos_r == '0) begin
      rd_sel = VSEL_NONE;
    end else begin
      rd_sel = VSEL_ROW;
    end
  end

  // Job control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nt_r           <= alt_pkg::NT_RESET;
      job_rows_r     <= '0;
      links_loaded_r <= '0;
      pos_r          <= '0;
      pend_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        nt_r <= cfg_wdata;
      end
      if (build_start) begin
        job_rows_r <= eff_rows;
        pend_r     <= 1'b1;
      end else if (inject) begin
        pend_r <= 1'b0;
      end
      if (ld_ok) begin
        links_loaded_r <= links_loaded_r + LC'(1);
      end else if (rd_issue && rd_last) begin
        links_loaded_r <= '0;
      end
      if (rd_issue) begin
        pos_r <= rd_last ? '0 : pos_p1;
      end
    end
  end

  // Link store: write on a good load, read in the scatter walk
  assign sa_go = ctl.scatter_on && (si_r < links_loaded_r);

  always_ff @(posedge clk) begin
    if (ld_ok) begin
      link_mem[links_loaded_r[LI-1:0]] <= {in_ch.target_entity, in_ch.source_node};
    end
    if (sa_go) begin
      link_rd_r <= link_mem[si_r[LI-1:0]];
    end
  end

  // Count memory: increment on loads, zero during sweeps
  assign c_cur   = (lwc_v_r && (lwc_addr_r == s1_addr_r)) ? lwc_data_r : cnt_rd_r;
  assign cnt_inc = c_cur + LC'(1);
  assign c_re    = ld_ok || ctl.prefix_on;
  assign c_raddr = ctl.prefix_on ? sweep : TI'(in_ch.target_entity);
  assign c_we    = ctl.sweep_on || (adv && s1_v_r && s1_inc_r);
  assign c_waddr = ctl.sweep_on ? sweep : s1_addr_r;
  assign c_wdata = ctl.sweep_on ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (c_we) begin
      cnt_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      cnt_rd_r <= cnt_mem[c_raddr];
    end
  end

  // Hold the last count write for a load that read the same entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lwc_v_r <= 1'b0;
    end else if (ctl.sweep_on) begin
      lwc_v_r <= 1'b0;
    end else if (adv) begin
      lwc_v_r <= s1_v_r && s1_inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lwc_addr_r <= s1_addr_r;
      lwc_data_r <= cnt_inc;
    end
  end

  // Prefix stage: accumulate counts into exclusive row offsets
  assign p_hit = CW'(paddr_r) < CW'(job_rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      run_r <= '0;
    end else begin
      pv_r <= ctl.prefix_on;
      if (build_start) begin
        run_r <= '0;
      end else if (pv_r && p_hit) begin
        run_r <= run_r + cnt_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= sweep;
  end

  // Scatter walk: link read, row pointer read, placement
  assign link_tg = link_rd_r[alt_pkg::SRC_W +: alt_pkg::TGT_W];
  assign sb_hit  = CW'(link_tg) < CW'(job_rows_r);
  assign slot    = (lwf_v_r && (lwf_addr_r == sc_tg_r)) ? lwf_data_r : fill_rd_r;
  assign slot_p1 = slot + LC'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r    <= '0;
      sb_v_r  <= 1'b0;
      sc_v_r  <= 1'b0;
      lwf_v_r <= 1'b0;
    end else begin
      if (ctl.prefix_on) begin
        si_r <= '0;
      end else if (sa_go) begin
        si_r <= si_r + LC'(1);
      end
      sb_v_r  <= sa_go;
      sc_v_r  <= sb_v_r && sb_hit;
      lwf_v_r <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_tg_r    <= TI'(link_tg);
    sc_src_r   <= link_rd_r[alt_pkg::SRC_W-1:0];
    lwf_addr_r <= sc_tg_r;
    lwf_data_r <= slot_p1;
  end

  // Row pointer memory: start offsets from the prefix, end offsets after scatter
  assign f_re    = (sb_v_r && sb_hit) || (rd_issue && (rd_sel == VSEL_ROW));
  assign f_raddr = ctl.read_on ? TI'(pos_r - PW'(1)) : TI'(link_tg);
  assign f_we    = (pv_r && p_hit) || sc_v_r;
  assign f_waddr = pv_r ? paddr_r : sc_tg_r;
  assign f_wdata = pv_r ? run_r : slot_p1;

  always_ff @(posedge clk) begin
    if (f_we) begin
      fill_mem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      fill_rd_r <= fill_mem[f_raddr];
    end
  end

  // Transposed connection memory
  always_ff @(posedge clk) begin
    if (sc_v_r) begin
      tr_mem[slot[LI-1:0]] <= sc_src_r;
    end
    if (rd_issue && (rd_sel == VSEL_LINK)) begin
      tr_rd_r <= tr_mem[rd_k[LI-1:0]];
    end
  end

  // Result stage: pick the word once memory data is back
  always_comb begin
    unique case (s1_sel_r)
      VSEL_ROW:  s1_val = alt_pkg::VAL_W'(fill_rd_r);
      VSEL_LINK: s1_val = tr_rd_r;
      default:   s1_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= ld_issue || rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_stat_r <= ld_issue ? ld_stat : alt_pkg::STAT_OK;
      s1_sel_r  <= ld_issue ? VSEL_NONE : rd_sel;
      s1_kind_r <= (rd_issue && !rd_row) ? alt_pkg::KIND_LINK : alt_pkg::KIND_OFFSET;
      s1_last_r <= rd_issue && rd_last;
      s1_inc_r  <= ld_ok;
      s1_addr_r <= TI'(in_ch.target_entity);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stat_r <= s1_stat_r;
      out_kind_r <= s1_kind_r;
      out_val_r  <= s1_val;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.word_kind  = out_kind_r;
  assign out_ch.word_value = out_val_r;
  assign out_ch.last_word  = out_last_r;

  // Checks
  `ALT_ASSERT_IMP(a_build_pipe_empty, ctl.prefix_on || ctl.scatter_on, !s1_v_r && pend_r)
  `ALT_ASSERT_IMP(a_slot_in_store, sc_v_r, slot < LC'(MAX_LINKS))
  `ALT_ASSERT_IMP(a_read_in_range, rd_issue, pos_r < total)
  `ALT_ASSERT_NXT(a_last_ends_job, rd_issue && rd_last, ctl.load_on && (links_loaded_r == '0))

endmodule

@@ rtl/core/alt_ctrl.sv @@
// Phase sequencer of the adjacency list transpose: clear, load, prefix,
// scatter and readout phases, plus the row sweep counter. Depends on alt_pkg.
module alt_ctrl #(
  parameter int MAX_TARGETS = alt_pkg::MAX_TARGETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  alt_pkg::ctl_ev_t                ev,
  output alt_pkg::ctl_t                   ctl,
  output logic [$clog2(MAX_TARGETS)-1:0]  sweep_idx
);

  localparam int TI = $clog2(MAX_TARGETS);

  alt_pkg::fsm_state_t state_r, state_nxt;
  logic [TI-1:0]       sweep_r, sweep_nxt;
  logic                sweep_last;

  assign sweep_last = (sweep_r == TI'(MAX_TARGETS - 1));
  assign sweep_idx  = sweep_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alt_pkg::S_CLEAR:   if (sweep_last)       state_nxt = alt_pkg::S_LOAD;
      alt_pkg::S_LOAD:    if (ev.build_start)   state_nxt = alt_pkg::S_PREFIX;
      alt_pkg::S_PREFIX:  if (sweep_last)       state_nxt = alt_pkg::S_SCATTER;
      alt_pkg::S_SCATTER: if (ev.scatter_done)  state_nxt = alt_pkg::S_READ;
      alt_pkg::S_READ:    if (ev.read_end)      state_nxt = alt_pkg::S_LOAD;
      default:                                  state_nxt = alt_pkg::S_CLEAR;
    endcase
  end

  // Phase flags
  always_comb begin
    ctl = '0;
    unique case (state_r)
      alt_pkg::S_CLEAR:   ctl.sweep_on = 1'b1;
      alt_pkg::S_LOAD:    ctl.load_on = 1'b1;
      alt_pkg::S_PREFIX: begin
        ctl.prefix_on = 1'b1;
        ctl.sweep_on  = 1'b1;
      end
      alt_pkg::S_SCATTER: ctl.scatter_on = 1'b1;
      alt_pkg::S_READ:    ctl.read_on = 1'b1;
      default:            ctl = '0;
    endcase
  end

  // Advance the sweep across all rows, restart at zero outside a sweep
  always_comb begin
    sweep_nxt = '0;
    if (ctl.sweep_on && !sweep_last) begin
      sweep_nxt = sweep_r + TI'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alt_pkg::S_CLEAR;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for adjacency_list_transpose: random link loads and readouts.
// Depends on alt_pkg, alt_in_if, alt_out_if and the block's RTL.
module testbench;
  import alt_pkg::*;

  // Tracks the block's state and keeps the words it should return, oldest first
  class transpose_tracker;
    typedef struct {
      status_t          status;
      logic             kind;
      logic [VAL_W-1:0] value;
      logic             last;
    } word_t;

    int unsigned      row_limit;
    logic [SRC_W-1:0] link_src[MAX_LINKS_DEF];
    logic [TGT_W-1:0] link_tgt[MAX_LINKS_DEF];
    int unsigned      per_row[MAX_TARGETS_DEF];
    int unsigned      row_base[MAX_TARGETS_DEF+1];
    int unsigned      row_used[MAX_TARGETS_DEF];
    logic [SRC_W-1:0] row_sorted[MAX_LINKS_DEF];
    int unsigned      stored;
    int unsigned      read_pos;
    int unsigned      job_rows;
    bit               reading;
    word_t            words_due[$];
    int unsigned      faults;

    function new();
      row_limit = NT_RESET;
      foreach (per_row[t]) per_row[t] = 0;
      stored   = 0;
      read_pos = 0;
      job_rows = 0;
      reading  = 1'b0;
      faults   = 0;
    endfunction

    function int unsigned rows_in_use();
      return (row_limit > MAX_TARGETS_DEF) ? MAX_TARGETS_DEF : row_limit;
    endfunction

    // Latch the row count, form the prefix offsets and fill the rows in load order
    function void build_rows();
      int unsigned t;
      int unsigned i;
      int unsigned slot;
      job_rows = rows_in_use();
      row_base[0] = 0;
      for (t = 0; t < job_rows; t++) begin
        row_base[t+1] = row_base[t] + per_row[t];
        row_used[t] = 0;
      end
      for (i = 0; i < stored; i++) begin
        t = link_tgt[i];
        if (t < job_rows) begin
          slot = row_base[t] + row_used[t];
          row_used[t]++;
          row_sorted[slot] = link_src[i];
        end
      end
      reading  = 1'b1;
      read_pos = 0;
    endfunction

    // Note one accepted item and queue the word it causes
    function status_t take_item(logic act, logic [SRC_W-1:0] src, logic [TGT_W-1:0] tgt);
      word_t       w;
      int unsigned total;
      w.status = STAT_OK;
      w.kind   = KIND_OFFSET;
      w.value  = '0;
      w.last   = 1'b0;
      if (act == ACT_LOAD) begin
        if (reading)
          w.status = STAT_BUSY;
        else if (tgt >= rows_in_use())
          w.status = STAT_RANGE;
        else if (stored >= MAX_LINKS_DEF)
          w.status = STAT_FULL;
        else begin
          link_src[stored] = src;
          link_tgt[stored] = tgt;
          per_row[tgt]++;
          stored++;
        end
      end else begin
        if (!reading) build_rows();
        total = job_rows + 1 + row_base[job_rows];
        if (read_pos <= job_rows) begin
          w.value = VAL_W'(row_base[read_pos]);
        end else begin
          w.kind  = KIND_LINK;
          w.value = row_sorted[read_pos - job_rows - 1];
        end
        if (read_pos + 1 >= total) begin
          w.last = 1'b1;
          foreach (per_row[t]) per_row[t] = 0;
          stored   = 0;
          reading  = 1'b0;
          read_pos = 0;
        end else begin
          read_pos++;
        end
      end
      words_due = {words_due, w};
      return w.status;
    endfunction

    // Compare one returned word with the oldest one due
    function void match_word(logic [STAT_W-1:0] st, logic kind, logic [VAL_W-1:0] value,
                             logic last);
      word_t w;
      if (words_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: status %0d kind %0d value %0h last %0d",
                   st, kind, value, last);
        return;
      end
      w = words_due.pop_front();
      if (st !== w.status || kind !== w.kind || value !== w.value || last !== w.last) begin
        faults++;
        if (faults <= 10)
          $display({"word mismatch: expected status %0d kind %0d value %0h last %0d,",
                    " got status %0d kind %0d value %0h last %0d"},
                   w.status, w.kind, w.value, w.last, st, kind, value, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [NT_W-1:0] cfg_wdata;

  alt_in_if  in_ch();
  alt_out_if out_ch();

  transpose_tracker tracker;
  bit quiet;
  int unsigned done_items;

  adjacency_list_transpose dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #2 clk = ~clk;

  // Check each result transfer, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.match_word(out_ch.status, out_ch.word_kind, out_ch.word_value, out_ch.last_word);
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 37);
  end

  // Offer one item after random idle cycles and hold it until the transfer
  task automatic send(input logic act, input logic [SRC_W-1:0] src,
                      input logic [TGT_W-1:0] tgt);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.source_node   <= src;
    in_ch.target_entity <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(tracker.take_item(act, src, tgt));
    done_items++;
  endtask

  // Drop valid and wait until every due word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.words_due.size() != 0);
  endtask

  task automatic write_rows(input int unsigned rows);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= NT_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.row_limit = rows & 11'h7FF;
  endtask

  // Read words until the last one, with optional stray loads and register writes
  task automatic read_job(input int busy_pct, input int cfg_pct);
    bit cfg_done;
    cfg_done = 1'b0;
    do begin
      if (tracker.reading && $urandom_range(0, 99) < busy_pct)
        send(ACT_LOAD, SRC_W'($urandom), TGT_W'($urandom));
      if (tracker.reading && !cfg_done && $urandom_range(0, 99) < cfg_pct) begin
        write_rows($urandom_range(0, 64));
        cfg_done = 1'b1;
      end
      send(ACT_READ, SRC_W'($urandom), TGT_W'($urandom));
    end while (tracker.reading);
  endtask

  // One job: maybe a new row count, ascending loads with some noise, full readout
  task automatic random_job();
    int unsigned rows;
    int unsigned eff;
    int unsigned n;
    int unsigned src;
    int unsigned mid;
    int unsigned p;
    int unsigned i;
    bit          shift_rows;
    quiet = (done_items >= 300 && done_items < 500);
    if ($urandom_range(0, 99) < 75) begin
      p = $urandom_range(0, 99);
      rows = (p < 3) ? 0 : (p < 10) ? 1 :
             (p < 75) ? $urandom_range(2, 8) : $urandom_range(9, 64);
      write_rows(rows);
    end
    n          = $urandom_range(0, 24);
    src        = $urandom_range(0, 65000);
    mid        = $urandom_range(0, 24);
    shift_rows = ($urandom_range(0, 9) == 0);
    for (i = 0; i < n; i++) begin
      if (shift_rows && i == mid) write_rows($urandom_range(1, 16));
      eff = tracker.rows_in_use();
      p   = $urandom_range(0, 99);
      if ((p < 8 || eff == 0) && eff < 1024)
        send(ACT_LOAD, SRC_W'(src), TGT_W'($urandom_range(eff, 1023)));
      else if (p < 12)
        send(ACT_LOAD, SRC_W'($urandom), TGT_W'($urandom_range(0, eff - 1)));
      else begin
        src += $urandom_range(0, 3);
        send(ACT_LOAD, SRC_W'(src), TGT_W'($urandom_range(0, eff - 1)));
      end
    end
    read_job(4, 2);
  endtask

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned i;
    tracker             = new();
    quiet               = 1'b0;
    done_items          = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_LOAD;
    in_ch.source_node   = '0;
    in_ch.target_entity = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Four rows: field extremes, out-of-range targets, a load during readout
    write_rows(4);
    send(ACT_LOAD, 16'h0000, 10'd0);
    send(ACT_LOAD, 16'hFFFF, 10'd3);
    send(ACT_LOAD, 16'h5555, 10'd3);
    send(ACT_LOAD, 16'hAAAA, 10'd1);
    send(ACT_LOAD, 16'h0007, 10'd4);
    send(ACT_LOAD, 16'h0008, 10'h3FF);
    send(ACT_READ, 16'hFFFF, 10'h3FF);
    send(ACT_LOAD, 16'hFFFF, 10'h3FF);
    read_job(0, 0);

    // No rows: every load is out of range, readout is a single offset
    write_rows(0);
    send(ACT_LOAD, 16'h0001, 10'd0);
    read_job(0, 0);

    // Shrink the row count between loads, then rewrite it during the readout
    write_rows(3);
    send(ACT_LOAD, 16'h0002, 10'd2);
    send(ACT_LOAD, 16'h0003, 10'd0);
    write_rows(2);
    send(ACT_LOAD, 16'h0004, 10'd1);
    send(ACT_READ, 16'h0000, 10'd0);
    write_rows(5);
    read_job(0, 0);

    // Random jobs, mostly small
    while (done_items < 1000) random_job();
    quiet = 1'b0;

    // Register above the row maximum: the top row takes loads, read the first words
    write_rows(11'h7FF);
    send(ACT_LOAD, 16'h0000, 10'd0);
    send(ACT_LOAD, 16'h0010, 10'h3FF);
    for (i = 0; i < 4; i++) send(ACT_LOAD, SRC_W'(16'h0100 + i), TGT_W'($urandom));
    for (i = 0; i < 24; i++) send(ACT_READ, SRC_W'($urandom), TGT_W'($urandom));

    drain();
    repeat (16) @(posedge clk);
    if (tracker.faults == 0 && tracker.words_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
